[hw/rtl/utf8d_pkg.sv]
package utf8d_pkg;

    localparam int unsigned CP_W = 21;

    // lead byte classes and masks
    localparam logic [7:0] TOP_BIT    = 8'b1000_0000;
    localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
    localparam logic [7:0] LEAD2_CODE = 8'b1100_0000;
    localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
    localparam logic [7:0] LEAD3_CODE = 8'b1110_0000;
    localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
    localparam logic [7:0] LEAD4_CODE = 8'b1111_0000;
    localparam logic [7:0] LEAD_MIN   = 8'hC0;
    localparam logic [7:0] LEAD_MAX   = 8'hF4;
    localparam logic [5:0] CONT_BITS  = 6'b11_1111;

    typedef struct packed {
        logic [1:0]      bytes_owed;
        logic [CP_W-1:0] accumulator;
        logic            failed;
    } dec_state_t;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] codepoint;
        logic            decode_error;
        logic            text_done;
    } dec_result_t;

endpackage

[hw/rtl/utf8d_decode.sv]
module utf8d_decode
(
    input  utf8d_pkg::dec_state_t  state_cur,
    input  logic [7:0]             data_byte,
    input  logic                   end_of_text,
    output utf8d_pkg::dec_state_t  state_next,
    output utf8d_pkg::dec_result_t result
);
    import utf8d_pkg::*;

    logic            err;
    logic            emit;
    logic [CP_W-1:0] cp;
    dec_state_t      upd;

    // classify the word against the current sequence state
    always_comb
    begin
        err  = 1'b0;
        emit = 1'b0;
        cp   = '0;
        upd  = state_cur;
        if (state_cur.bytes_owed == 2'd0)
        begin
            if ((data_byte & TOP_BIT) == 8'd0)
            begin
                cp   = {{(CP_W-8){1'b0}}, data_byte};
                emit = 1'b1;
            end
            else if (data_byte < LEAD_MIN || data_byte > LEAD_MAX)
            begin
                err = 1'b1;
            end
            else if ((data_byte & LEAD2_MASK) == LEAD2_CODE)
            begin
                upd.bytes_owed  = 2'd1;
                upd.accumulator = {{(CP_W-5){1'b0}}, data_byte[4:0]};
            end
            else if ((data_byte & LEAD3_MASK) == LEAD3_CODE)
            begin
                upd.bytes_owed  = 2'd2;
                upd.accumulator = {{(CP_W-4){1'b0}}, data_byte[3:0]};
            end
            else
            begin
                upd.bytes_owed  = 2'd3;
                upd.accumulator = {{(CP_W-3){1'b0}}, data_byte[2:0]};
            end
        end
        else
        begin
            if ((data_byte & TOP_BIT) == 8'd0)
            begin
                err = 1'b1;
            end
            else
            begin
                upd.accumulator = {state_cur.accumulator[CP_W-7:0], data_byte[5:0] & CONT_BITS};
                upd.bytes_owed  = state_cur.bytes_owed - 2'd1;
                if (upd.bytes_owed == 2'd0)
                begin
                    cp   = upd.accumulator;
                    emit = 1'b1;
                end
            end
        end
        // flag a sequence cut short by end of text
        if (!err && end_of_text && upd.bytes_owed != 2'd0)
        begin
            err = 1'b1;
        end
    end

    // pick next state and result
    always_comb
    begin
        state_next          = upd;
        result.emit         = 1'b0;
        result.codepoint    = '0;
        result.decode_error = 1'b0;
        result.text_done    = end_of_text;
        if (state_cur.failed)
        begin
            // drop words until end of text
            state_next = end_of_text ? '0 : state_cur;
        end
        else if (err)
        begin
            state_next          = '0;
            state_next.failed   = !end_of_text;
            result.emit         = 1'b1;
            result.decode_error = 1'b1;
        end
        else
        begin
            if (end_of_text)
            begin
                state_next = '0;
            end
            result.emit      = emit;
            result.codepoint = cp;
        end
    end

endmodule

[hw/rtl/utf8_stream_decoder.sv]
// UTF-8 stream decoder and validator.
// Input channel: in_valid/in_ready carry one text word (data_byte plus
// end_of_text) per transfer. Output channel: out_valid/out_ready carry one
// result word (codepoint, decode_error, text_done) per decoded character or
// per first error of a text; words that finish no character give no result.
// An accepted word is held in the input register, decoded by the
// shallow per-byte logic, and its result is registered in the output
// register once that register is free.
// Throughput is one word per cycle while the receiver does not stall, with
// the sequence state (bytes owed, accumulator, failed flag) updated per word.
// When the receiver stalls, the result is held in the output register and
// the input register holds its word only if that word would emit a result;
// in_ready then drops until the output register frees up.
// Reset clears both registers' valid flags and the sequence state, so the
// first word after reset starts a new text.
module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [utf8d_pkg::CP_W-1:0] codepoint,
    output logic        decode_error,
    output logic        text_done
);
    import utf8d_pkg::*;

    logic            s1_valid_reg;
    logic [7:0]      s1_byte_reg;
    logic            s1_eot_reg;
    dec_state_t      state_reg;
    dec_state_t      state_next;
    dec_result_t     result;
    logic            out_valid_reg;
    logic [CP_W-1:0] cp_reg;
    logic            err_reg;
    logic            done_reg;
    logic            out_free;
    logic            s1_advance;

    utf8d_decode u_decode
    (
        .state_cur   (state_reg),
        .data_byte   (s1_byte_reg),
        .end_of_text (s1_eot_reg),
        .state_next  (state_next),
        .result      (result)
    );

    // advance stage one when its result, if any, has room
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && (!result.emit || out_free);
    assign in_ready   = !s1_valid_reg || s1_advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_eot_reg  <= end_of_text;
        end
    end

    // sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (s1_advance)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg && result.emit)
        begin
            cp_reg   <= result.codepoint;
            err_reg  <= result.decode_error;
            done_reg <= result.text_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign codepoint    = cp_reg;
    assign decode_error = err_reg;
    assign text_done    = done_reg;

    // an error result never carries a code point
    a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && err_reg |-> cp_reg == '0)
        else $error("error result with nonzero codepoint");

    // failed state keeps no partial sequence
    a_failed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.failed |-> state_reg.bytes_owed == 2'd0 && state_reg.accumulator == '0)
        else $error("failed state holds partial sequence");

    // an accepted word lands in the input register
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted word lost");

    // a stalled result blocks any word that would emit
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(s1_advance && result.emit))
        else $error("result register overrun");

endmodule

[tb/utf8_stream_decoder_tb.sv]
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

    import utf8d_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned TAIL_CYCLES = 8;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic [7:0]      data_byte = 8'h00;
    logic            end_of_text = 1'b0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [CP_W-1:0] codepoint;
    logic            decode_error;
    logic            text_done;

    // predictor state: bytes still owed, gathered code point bits, sticky failure
    logic [1:0]      owed_q = '0;
    logic [CP_W-1:0] acc_q = '0;
    logic            failed_q = 1'b0;

    dec_result_t     expected_chars[$];
    int unsigned     idle_pct = 13;
    int unsigned     stall_pct = 13;
    int unsigned     mismatches = 0;
    int unsigned     quiet_cycles = 0;

    utf8_stream_decoder dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .codepoint    (codepoint),
        .decode_error (decode_error),
        .text_done    (text_done)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Decode one byte against the predictor state; return 1 when it yields a result.
    function automatic logic decode_byte(input logic [7:0] b, input logic eot,
                                         output dec_result_t r);
        logic            err;
        logic            emit;
        logic [CP_W-1:0] cp;
        err  = 1'b0;
        emit = 1'b0;
        cp   = '0;
        r    = '0;
        // drop everything after an error until the text ends
        if (failed_q)
        begin
            if (eot)
            begin
                owed_q   = '0;
                acc_q    = '0;
                failed_q = 1'b0;
            end
            return 1'b0;
        end
        if (owed_q == 2'd0)
        begin
            if ((b & TOP_BIT) == 8'h00)
            begin
                cp   = CP_W'(b);
                emit = 1'b1;
            end
            else if (b < LEAD_MIN || b > LEAD_MAX)
                err = 1'b1;
            else if ((b & LEAD2_MASK) == LEAD2_CODE)
            begin
                owed_q = 2'd1;
                acc_q  = CP_W'(b[4:0]);
            end
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
            begin
                owed_q = 2'd2;
                acc_q  = CP_W'(b[3:0]);
            end
            else
            begin
                owed_q = 2'd3;
                acc_q  = CP_W'(b[2:0]);
            end
        end
        else
        begin
            // any byte with the top bit set counts as a continuation
            if ((b & TOP_BIT) == 8'h00)
                err = 1'b1;
            else
            begin
                acc_q  = {acc_q[CP_W-7:0], b[5:0] & CONT_BITS};
                owed_q = owed_q - 2'd1;
                if (owed_q == 2'd0)
                begin
                    cp   = acc_q;
                    emit = 1'b1;
                end
            end
        end
        // text cut short inside a character
        if (!err && eot && owed_q != 2'd0)
            err = 1'b1;
        if (err)
        begin
            owed_q   = '0;
            acc_q    = '0;
            failed_q = !eot;
            r.emit         = 1'b1;
            r.codepoint    = '0;
            r.decode_error = 1'b1;
            r.text_done    = eot;
            return 1'b1;
        end
        if (eot)
        begin
            owed_q   = '0;
            acc_q    = '0;
            failed_q = 1'b0;
        end
        if (emit)
        begin
            r.emit         = 1'b1;
            r.codepoint    = cp;
            r.decode_error = 1'b0;
            r.text_done    = eot;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one word after a random idle gap, hold it until accepted, then predict.
    task automatic send_word(input logic [7:0] b, input logic eot);
        logic        ready_seen;
        logic        has_result;
        dec_result_t r;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_text <= eot;
        forever
        begin
            @(negedge clk);
            ready_seen = in_ready;
            @(posedge clk);
            if (ready_seen)
                break;
        end
        has_result = decode_byte(b, eot, r);
        if (has_result)
            expected_chars.push_back(r);
    endtask

    // Randomize the receiver's stalls.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check each result word against the oldest expectation.
    always @(negedge clk)
    begin
        dec_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual cp=%h err=%b done=%b",
                         $time, codepoint, decode_error, text_done);
                mismatches++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (codepoint !== want.codepoint)
                begin
                    $display("%0t: codepoint mismatch: expected %h, actual %h",
                             $time, want.codepoint, codepoint);
                    mismatches++;
                end
                if (decode_error !== want.decode_error)
                begin
                    $display("%0t: decode_error mismatch: expected %b, actual %b",
                             $time, want.decode_error, decode_error);
                    mismatches++;
                end
                if (text_done !== want.text_done)
                begin
                    $display("%0t: text_done mismatch: expected %b, actual %b",
                             $time, want.text_done, text_done);
                    mismatches++;
                end
            end
        end
    end

    // End the run when neither channel moves a word for too long.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: timeout with %0d results outstanding",
                         $time, expected_chars.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Field extremes, every length and every error path.
    task automatic test_directed();
        send_word(8'h00, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hC2, 1'b0);
        send_word(8'hA9, 1'b0);
        // lowest two-byte lead, overlong form passes
        send_word(8'hC0, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hE2, 1'b0);
        send_word(8'h82, 1'b0);
        send_word(8'hAC, 1'b0);
        send_word(8'hF0, 1'b0);
        send_word(8'h9F, 1'b0);
        send_word(8'h98, 1'b0);
        send_word(8'h80, 1'b0);
        // highest lead, continuation above 0xBF, character ends the text
        send_word(8'hF4, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hBF, 1'b0);
        send_word(8'hFF, 1'b1);
        // stray continuation as lead, then dropped bytes, end clears quietly
        send_word(8'h80, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'hBF, 1'b1);
        // lead beyond the Unicode range
        send_word(8'hF5, 1'b0);
        send_word(8'hFF, 1'b1);
        // continuation below 0x80 is not retried as a lead
        send_word(8'hE2, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(8'h7F, 1'b1);
        // text cut short inside a character
        send_word(8'hC2, 1'b1);
        send_word(8'h41, 1'b1);
    endtask

    // Mostly well-formed characters with random content, mixed with noise bytes.
    task automatic test_random_text(input int unsigned count);
        int unsigned sent;
        int unsigned len;
        int unsigned k;
        logic [7:0]  b;
        logic        eot;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 75)
            begin
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                begin
                    if (k == 0)
                    begin
                        case (len)
                            1: b = 8'($urandom_range(8'h00, 8'h7F));
                            2: b = 8'($urandom_range(8'hC0, 8'hDF));
                            3: b = 8'($urandom_range(8'hE0, 8'hEF));
                            default: b = 8'($urandom_range(8'hF0, 8'hF4));
                        endcase
                    end
                    else
                        b = 8'($urandom_range(8'h80, 8'hFF));
                    if (k == len - 1)
                        eot = ($urandom_range(99) < 6);
                    else
                        eot = ($urandom_range(99) < 2);
                    send_word(b, eot);
                    sent++;
                end
            end
            else
            begin
                b   = 8'($urandom_range(0, 255));
                eot = ($urandom_range(99) < 10);
                send_word(b, eot);
                sent++;
            end
        end
    endtask

    // Hold off the sender until every expected result has come back, then send more random text.
    task automatic test_drain_pause();
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        test_random_text(40);
    endtask

    // Back-to-back words with the receiver always ready.
    task automatic test_full_rate();
        idle_pct  = 0;
        stall_pct = 0;
        test_random_text(400);
        idle_pct  = 13;
        stall_pct = 13;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_text(650);
        test_drain_pause();
        test_full_rate();
        test_random_text(300);

        // drain and let the pipeline settle
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
